>>> src/oriented_box_overlap_test_2d_defines.svh
// Assertion macros for the oriented box overlap test
`ifndef ORIENTED_BOX_OVERLAP_TEST_2D_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_TEST_2D_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define OBOT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

`define OBOT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`else

`define OBOT_ASSERT_SAME(label, ante, cons)

`define OBOT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> src/obot_pkg.sv
// Shared constants and index tables for the oriented box overlap test
`timescale 1ns / 1ps

package obot_pkg;

  localparam int COORD_WIDTH_DEF = 24;
  localparam int NUM_EDGES       = 4;
  localparam int NUM_PAIRS       = 10;
  localparam int NUM_STAGES      = 5;

  typedef logic [1:0] edge_idx_t;
  typedef logic [3:0] pair_idx_t;

  localparam edge_idx_t PAIR_A [NUM_PAIRS] = '{2'd0, 2'd0, 2'd0, 2'd0, 2'd1,
                                               2'd1, 2'd1, 2'd2, 2'd2, 2'd3};
  localparam edge_idx_t PAIR_B [NUM_PAIRS] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd1,
                                               2'd2, 2'd3, 2'd2, 2'd3, 2'd3};

  localparam pair_idx_t PAIR_OF [NUM_EDGES][NUM_EDGES] = '{
    '{4'd0, 4'd1, 4'd2, 4'd3},
    '{4'd1, 4'd4, 4'd5, 4'd6},
    '{4'd2, 4'd5, 4'd7, 4'd8},
    '{4'd3, 4'd6, 4'd8, 4'd9}
  };

endpackage

>>> src/oriented_box_overlap_test_2d.sv
// Separating-axis overlap test for two 2D oriented rectangles
//
//   channel  handshake            payload
//   in_      in_valid / in_stall  two boxes: centre, edge a, edge b (x, y)
//   out_     out_valid/out_stall  out_boxes_overlap
//
// One transaction per cycle while out_stall is low; the pipeline stages are:
// input register, products, dot magnitudes, axis sums, result register.
// The product stage (28 multipliers of COORD_WIDTH+1 bits) sets the pace.
// Reset clears only the stage valid flags.
// out_stall holds occupied stages; empty stages keep filling, so bubbles close up.
`timescale 1ns / 1ps
`include "oriented_box_overlap_test_2d_defines.svh"

module oriented_box_overlap_test_2d import obot_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] in_first_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_first_edge_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_edge_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_first_edge_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_edge_b_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_center_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_edge_a_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_edge_a_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_edge_b_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_edge_b_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_boxes_overlap
);

  localparam int OW = COORD_WIDTH + 1;
  localparam int PW = 2 * OW;
  localparam int MW = PW + 1;
  localparam int SW = MW + 2;

  logic [NUM_STAGES-1:0] vld_r;
  logic [NUM_STAGES-1:0] vld_nxt;
  logic [NUM_STAGES-1:0] stage_load;

  logic signed [OW-1:0] ex_nxt [NUM_EDGES];
  logic signed [OW-1:0] ey_nxt [NUM_EDGES];
  logic signed [OW-1:0] ex_r   [NUM_EDGES];
  logic signed [OW-1:0] ey_r   [NUM_EDGES];
  logic signed [OW-1:0] dx_nxt, dy_nxt, dx_r, dy_r;

  logic signed [PW-1:0] pex_r [NUM_PAIRS];
  logic signed [PW-1:0] pey_r [NUM_PAIRS];
  logic signed [PW-1:0] pdx_r [NUM_EDGES];
  logic signed [PW-1:0] pdy_r [NUM_EDGES];

  logic signed [MW-1:0] dot_e [NUM_PAIRS];
  logic signed [MW-1:0] dot_d [NUM_EDGES];
  logic        [MW-1:0] me_r  [NUM_PAIRS];
  logic        [MW-1:0] md_r  [NUM_EDGES];

  logic [SW-1:0] sum_nxt [NUM_EDGES];
  logic [SW-1:0] dbl_nxt [NUM_EDGES];
  logic [SW-1:0] sum_r   [NUM_EDGES];
  logic [SW-1:0] dbl_r   [NUM_EDGES];

  logic [NUM_EDGES-1:0] apart;
  logic                 overlap_nxt;
  logic                 overlap_r;

  // stage handshake
  assign stage_load[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || !out_stall;
  assign vld_nxt[0] = stage_load[0] ? in_valid : vld_r[0];

  for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_load
    assign stage_load[k] = !vld_r[k] || stage_load[k+1];
    assign vld_nxt[k+1]  = stage_load[k+1] ? vld_r[k] : vld_r[k+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_stall  = !stage_load[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // stage 0: capture edges and centre offset
  assign ex_nxt[0] = OW'(in_first_edge_a_x);
  assign ey_nxt[0] = OW'(in_first_edge_a_y);
  assign ex_nxt[1] = OW'(in_first_edge_b_x);
  assign ey_nxt[1] = OW'(in_first_edge_b_y);
  assign ex_nxt[2] = OW'(in_second_edge_a_x);
  assign ey_nxt[2] = OW'(in_second_edge_a_y);
  assign ex_nxt[3] = OW'(in_second_edge_b_x);
  assign ey_nxt[3] = OW'(in_second_edge_b_y);
  assign dx_nxt    = OW'(in_second_center_x) - OW'(in_first_center_x);
  assign dy_nxt    = OW'(in_second_center_y) - OW'(in_first_center_y);

  always_ff @(posedge clk) begin
    if (stage_load[0]) begin
      ex_r <= ex_nxt;
      ey_r <= ey_nxt;
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  // stage 1: products
  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
    always_ff @(posedge clk) begin
      if (stage_load[1]) begin
        pex_r[p] <= PW'(ex_r[PAIR_A[p]]) * PW'(ex_r[PAIR_B[p]]);
        pey_r[p] <= PW'(ey_r[PAIR_A[p]]) * PW'(ey_r[PAIR_B[p]]);
      end
    end

    assign dot_e[p] = MW'(pex_r[p]) + MW'(pey_r[p]);

    always_ff @(posedge clk) begin
      if (stage_load[2]) begin
        me_r[p] <= dot_e[p][MW-1] ? (~dot_e[p] + MW'(1)) : dot_e[p];
      end
    end
  end

  // stages 1 to 3 per axis
  for (genvar i = 0; i < NUM_EDGES; i++) begin : g_axis
    always_ff @(posedge clk) begin
      if (stage_load[1]) begin
        pdx_r[i] <= PW'(ex_r[i]) * PW'(dx_r);
        pdy_r[i] <= PW'(ey_r[i]) * PW'(dy_r);
      end
    end

    assign dot_d[i] = MW'(pdx_r[i]) + MW'(pdy_r[i]);

    always_ff @(posedge clk) begin
      if (stage_load[2]) begin
        md_r[i] <= dot_d[i][MW-1] ? (~dot_d[i] + MW'(1)) : dot_d[i];
      end
    end

    assign sum_nxt[i] = SW'(me_r[PAIR_OF[i][0]]) + SW'(me_r[PAIR_OF[i][1]])
                      + SW'(me_r[PAIR_OF[i][2]]) + SW'(me_r[PAIR_OF[i][3]]);
    assign dbl_nxt[i] = SW'({md_r[i], 1'b0});

    always_ff @(posedge clk) begin
      if (stage_load[3]) begin
        sum_r[i] <= sum_nxt[i];
        dbl_r[i] <= dbl_nxt[i];
      end
    end

    assign apart[i] = sum_r[i] < dbl_r[i];
  end

  // stage 4: result register
  assign overlap_nxt = ~|apart;

  always_ff @(posedge clk) begin
    if (stage_load[4]) begin
      overlap_r <= overlap_nxt;
    end
  end

  assign out_boxes_overlap = overlap_r;

  `OBOT_ASSERT_SAME(a_full_stalls_input, (&vld_r) && out_stall, in_stall)
  `OBOT_ASSERT_NEXT(a_accept_fills_front, in_valid && !in_stall, vld_r[0])
  `OBOT_ASSERT_SAME(a_result_from_upstream, $rose(vld_r[NUM_STAGES-1]), $past(vld_r[NUM_STAGES-2]))

endmodule
